// ===== src/oahm_pkg.sv =====
// ----------------------------------------------------------------------------
// oahm_pkg
// Shared types and codes for the open-addressing hash map: operation and
// status codes, slot marks, slot record layout and the mixer constants.
// ----------------------------------------------------------------------------
`default_nettype none

package oahm_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 10;
	localparam int LIVE_W  = 11;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] mark_t;

	localparam op_t OP_PUT    = 2'd0;
	localparam op_t OP_GET    = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_ABSENT = 2'd1;
	localparam status_t ST_FULL   = 2'd2;

	localparam mark_t MARK_EMPTY  = 2'd0;
	localparam mark_t MARK_FILLED = 2'd1;
	localparam mark_t MARK_TOMB   = 2'd2;

	localparam logic [KEY_W-1:0] MIX_MUL_A = 32'h7feb352d;
	localparam logic [KEY_W-1:0] MIX_MUL_B = 32'h846ca68b;

	typedef struct packed {
		mark_t              mark;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] index;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

// ===== src/oahm_if.sv =====
// ----------------------------------------------------------------------------
// oahm_req_if / oahm_rsp_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface oahm_req_if;
	logic                                 valid;
	logic                                 ready;
	oahm_pkg::op_t                        operation;
	logic signed [oahm_pkg::KEY_W-1:0]    key;
	logic        [oahm_pkg::VALUE_W-1:0]  value;

	modport source (output valid, operation, key, value, input ready);
	modport sink   (input valid, operation, key, value, output ready);
endinterface

interface oahm_rsp_if;
	logic                                valid;
	logic                                ready;
	oahm_pkg::status_t                   status;
	logic [oahm_pkg::VALUE_W-1:0]        value_out;
	logic [oahm_pkg::LIVE_W-1:0]         live_entries;

	modport source (output valid, status, value_out, live_entries, input ready);
	modport sink   (input valid, status, value_out, live_entries, output ready);
endinterface

`default_nettype wire

// ===== src/oahm_ram.sv =====
// ----------------------------------------------------------------------------
// oahm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module oahm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/oahm_mix.sv =====
// ----------------------------------------------------------------------------
// oahm_mix
// Iterative multiply-xorshift key mixer. One 32x32 multiplier is shared by
// both multiply rounds; done flags the hash as ready.
// ----------------------------------------------------------------------------
`default_nettype none

module oahm_mix (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [oahm_pkg::KEY_W-1:0]   key,
	output logic                              done,
	output logic      [oahm_pkg::KEY_W-1:0]   hash
);
	import oahm_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MULA = 2'd1;
	localparam logic [1:0] PH_MULB = 2'd2;

	logic [1:0]       phase_q;
	logic [KEY_W-1:0] v_q;
	logic [KEY_W-1:0] hash_q;
	logic             done_q;
	logic [KEY_W-1:0] mul_k;
	logic [KEY_W-1:0] prod;

	// Shared multiplier, low word only.
	assign mul_k = (phase_q == PH_MULA) ? MIX_MUL_A : MIX_MUL_B;
	assign prod  = v_q * mul_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_MULB);
			unique case (phase_q)
				PH_IDLE: if (start) phase_q <= PH_MULA;
				PH_MULA: phase_q <= PH_MULB;
				PH_MULB: phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: if (start) v_q <= key ^ (key >> 16);
			PH_MULA: v_q <= prod ^ (prod >> 15);
			PH_MULB: hash_q <= prod ^ (prod >> 16);
			default: ;
		endcase
	end

	assign done = done_q;
	assign hash = hash_q;

endmodule

`default_nettype wire

// ===== src/open_addressing_hash_map.sv =====
// Per item: the two shared mixer multiply rounds, then the home slot read,
// then one slot per cycle, 1 to SLOT_COUNT slots in all, until a hit, an
// empty slot or the last slot; a stalled response output holds the last slot.
// One item at a time; the next request can be taken in the cycle after the
// response is loaded, the slot RAM read port setting the probe pace.
// Reset: a clearing pass marks all SLOT_COUNT slots empty, one per cycle;
// req.ready stays low until the pass is done.
// ----------------------------------------------------------------------------
// open_addressing_hash_map
// Linear-probing hash map with tombstones: put, get and remove on a signed
// 32-bit key, slot records held in one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_map #(
	parameter int SLOT_COUNT = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	oahm_req_if.sink   req,
	oahm_rsp_if.source rsp
);
	import oahm_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HASH  = 2'd2;
	localparam logic [1:0] S_PROBE = 2'd3;

	logic [1:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [CW-1:0]      filled_q;
	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [VALUE_W-1:0] rsp_value_q;

	op_t                op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      step_q;
	logic               tomb_seen_q;
	logic [AW-1:0]      tomb_addr_q;

	logic               accept;
	logic               mix_done;
	logic [KEY_W-1:0]   mix_hash;
	slot_t              slot;
	logic               is_empty, is_hit, is_tomb, last, stop, out_free, finish;
	logic               tomb_any;
	logic [AW-1:0]      tomb_target;

	logic               res_we;
	logic [AW-1:0]      res_waddr;
	slot_t              res_wdata;
	status_t            res_status;
	logic [VALUE_W-1:0] res_value;
	logic               fill_inc, fill_dec;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	slot_t              ram_wdata;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	oahm_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    ($unsigned(req.key)),
		.done   (mix_done),
		.hash   (mix_hash)
	);

	oahm_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (slot)
	);

	// Examine the slot last read from the RAM.
	assign is_empty    = (slot.mark == MARK_EMPTY);
	assign is_hit      = (slot.mark == MARK_FILLED) && (slot.key == key_q);
	assign is_tomb     = (slot.mark == MARK_TOMB);
	assign last        = (step_q == LAST_SLOT);
	assign stop        = (op_q != OP_PUT && op_q != OP_GET && op_q != OP_REMOVE) ||
	                     is_empty || is_hit || last;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign finish      = (state_q == S_PROBE) && stop && out_free;
	assign tomb_any    = tomb_seen_q || is_tomb;
	assign tomb_target = tomb_seen_q ? tomb_addr_q : addr_q;

	always_comb begin
		res_we     = 1'b0;
		res_waddr  = addr_q;
		res_wdata  = '{mark: MARK_FILLED, key: key_q, index: value_q};
		res_status = ST_ABSENT;
		res_value  = '0;
		fill_inc   = 1'b0;
		fill_dec   = 1'b0;
		unique case (op_q)
			OP_PUT: begin
				priority if (is_hit) begin
					res_we     = 1'b1;
					res_status = ST_OK;
				end else if (is_empty) begin
					// Reuse the first tombstone passed, else take the empty slot.
					res_we     = 1'b1;
					res_waddr  = tomb_seen_q ? tomb_addr_q : addr_q;
					res_status = ST_OK;
					fill_inc   = 1'b1;
				end else if (tomb_any) begin
					res_we     = 1'b1;
					res_waddr  = tomb_target;
					res_status = ST_OK;
					fill_inc   = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_GET: begin
				if (is_hit) begin
					res_status = ST_OK;
					res_value  = slot.index;
				end
			end
			OP_REMOVE: begin
				if (is_hit) begin
					res_we     = 1'b1;
					res_wdata  = '{mark: MARK_TOMB, key: slot.key, index: slot.index};
					res_status = ST_OK;
					fill_dec   = (filled_q != '0);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '{mark: MARK_EMPTY, key: '0, index: '0};
		end else begin
			ram_we    = finish && res_we;
			ram_waddr = res_waddr;
			ram_wdata = res_wdata;
		end
		ram_re    = ((state_q == S_HASH) && mix_done) || ((state_q == S_PROBE) && !stop);
		ram_raddr = (state_q == S_HASH) ? mix_hash[AW-1:0] : addr_q + AW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			filled_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SLOT) state_q <= S_IDLE;
				end
				S_IDLE:  if (accept) state_q <= S_HASH;
				S_HASH:  if (mix_done) state_q <= S_PROBE;
				S_PROBE: begin
					if (finish) begin
						state_q  <= S_IDLE;
						filled_q <= filled_q + CW'(fill_inc) - CW'(fill_dec);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			key_q   <= $unsigned(req.key);
			value_q <= req.value;
		end
		if (state_q == S_HASH && mix_done) begin
			addr_q      <= mix_hash[AW-1:0];
			step_q      <= '0;
			tomb_seen_q <= 1'b0;
		end
		if (state_q == S_PROBE && !stop) begin
			// Advance to the next slot, remembering the first tombstone.
			addr_q <= addr_q + AW'(1);
			step_q <= step_q + AW'(1);
			if (is_tomb && !tomb_seen_q) begin
				tomb_seen_q <= 1'b1;
				tomb_addr_q <= addr_q;
			end
		end
		if (finish) begin
			rsp_status_q <= res_status;
			rsp_value_q  <= res_value;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.value_out    = rsp_value_q;
	assign rsp.live_entries = LIVE_W'(filled_q);

endmodule

`default_nettype wire

// ===== src/oahm_checker.sv =====
// ----------------------------------------------------------------------------
// oahm_checker
// Port-level checks on the hash map: response hold, one item in flight,
// legal status codes and zero value on any status but OK.
// ----------------------------------------------------------------------------
`default_nettype none

module oahm_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             req_valid,
	input wire logic                             req_ready,
	input wire logic                             rsp_valid,
	input wire logic                             rsp_ready,
	input wire oahm_pkg::status_t                rsp_status,
	input wire logic [oahm_pkg::VALUE_W-1:0]     rsp_value_out,
	input wire logic [oahm_pkg::LIVE_W-1:0]      rsp_live_entries
);
	import oahm_pkg::*;

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_value_out) && $stable(rsp_live_entries))
		else $error("response changed while stalled");

	// An accepted item keeps the block busy for at least the mixer cycles.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
		else $error("request taken while an item is in flight");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_ABSENT ||
		rsp_status == ST_FULL))
		else $error("illegal status code");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_value_out == '0)
		else $error("nonzero value on a miss");

endmodule

bind open_addressing_hash_map oahm_checker u_oahm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_value_out    (rsp.value_out),
	.rsp_live_entries (rsp.live_entries)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for open_addressing_hash_map. Drives put, get and remove items
// through the request channel and predicts each response with a slot-level
// model of the linear-probing table kept in a scoreboard class. Covers
// extreme keys, colliding keys that wrap past the last slot, tombstone reuse,
// a long response stall and mixed traffic on a drained table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oahm_pkg::*;

	localparam int SLOTS            = 1024;
	localparam int CLUSTER_BASE     = SLOTS - 8;
	localparam int RANDOM_ITEMS     = 460;
	localparam int TAIL_ITEMS       = 60;
	localparam int LONG_HOLD        = 400;
	localparam int MAX_PRINTS       = 100;

	typedef struct {
		op_t                op;
		logic [KEY_W-1:0]   key;
		status_t            status;
		logic [VALUE_W-1:0] value_out;
		logic [LIVE_W-1:0]  live;
	} map_result_t;

	class hash_map_scoreboard;
		logic [KEY_W-1:0]   slot_key [SLOTS];
		logic [VALUE_W-1:0] slot_index [SLOTS];
		mark_t              slot_mark [SLOTS];
		int unsigned        filled;
		map_result_t        expected_results [$];
		int                 mismatches;
		int                 n_ok, n_absent, n_full;

		function new();
			foreach (slot_mark[i]) begin
				slot_mark[i]  = MARK_EMPTY;
				slot_key[i]   = '0;
				slot_index[i] = '0;
			end
			filled     = 0;
			mismatches = 0;
			n_ok       = 0;
			n_absent   = 0;
			n_full     = 0;
		endfunction

		function int unsigned home_slot(logic [KEY_W-1:0] k);
			logic [31:0] v;
			v = k ^ (k >> 16);
			v = v * MIX_MUL_A;
			v = v ^ (v >> 15);
			v = v * MIX_MUL_B;
			v = v ^ (v >> 16);
			return v & (SLOTS - 1);
		endfunction

		function logic [KEY_W-1:0] key_with_home(int unsigned slot);
			logic [KEY_W-1:0] k;
			do
				k = $urandom;
			while (home_slot(k) != slot);
			return k;
		endfunction

		// Walk the chain from the home slot: stop on an empty slot or the key.
		function void probe(logic [KEY_W-1:0] k, output int hit, output int empty_at,
				output int tomb_at);
			int unsigned h, p;
			hit      = -1;
			empty_at = -1;
			tomb_at  = -1;
			h        = home_slot(k);
			for (int i = 0; i < SLOTS; i++) begin
				p = (h + i) % SLOTS;
				if (slot_mark[p] == MARK_EMPTY) begin
					empty_at = p;
					break;
				end
				if (slot_mark[p] == MARK_TOMB) begin
					if (tomb_at < 0)
						tomb_at = p;
				end else if (slot_key[p] == k) begin
					hit = p;
					break;
				end
			end
		endfunction

		function void note_request(op_t op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
			map_result_t r;
			int          hit, empty_at, tomb_at, target;
			r.op        = op;
			r.key       = k;
			r.status    = ST_ABSENT;
			r.value_out = '0;
			probe(k, hit, empty_at, tomb_at);
			case (op)
				OP_PUT: begin
					// prefer the first tombstone passed over the empty slot
					target = (tomb_at >= 0) ? tomb_at : empty_at;
					if (hit >= 0) begin
						slot_index[hit] = v;
						r.status        = ST_OK;
					end else if (target >= 0) begin
						slot_key[target]   = k;
						slot_index[target] = v;
						slot_mark[target]  = MARK_FILLED;
						filled++;
						r.status = ST_OK;
					end else begin
						r.status = ST_FULL;
					end
				end
				OP_GET: begin
					if (hit >= 0) begin
						r.status    = ST_OK;
						r.value_out = slot_index[hit];
					end
				end
				OP_REMOVE: begin
					if (hit >= 0) begin
						slot_mark[hit] = MARK_TOMB;
						filled--;
						r.status = ST_OK;
					end
				end
				default: ;
			endcase
			r.live = LIVE_W'(filled);
			expected_results.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= MAX_PRINTS)
				$display("%0t mismatch: %s", $time, what);
		endtask

		task check_response(status_t st, logic [VALUE_W-1:0] vo, logic [LIVE_W-1:0] live);
			map_result_t e;
			case (st)
				ST_OK:     n_ok++;
				ST_ABSENT: n_absent++;
				ST_FULL:   n_full++;
				default: ;
			endcase
			if (expected_results.size() == 0) begin
				report($sformatf("response status %0d with no request pending", st));
				return;
			end
			e = expected_results.pop_front();
			if (st !== e.status)
				report($sformatf("op %0d key %h: status %0d, expected %0d",
					e.op, e.key, st, e.status));
			if (vo !== e.value_out)
				report($sformatf("op %0d key %h: value_out %0d, expected %0d",
					e.op, e.key, vo, e.value_out));
			if (live !== e.live)
				report($sformatf("op %0d key %h: live_entries %0d, expected %0d",
					e.op, e.key, live, e.live));
		endtask

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	oahm_req_if req_ch ();
	oahm_rsp_if rsp_ch ();

	hash_map_scoreboard sb;
	logic [KEY_W-1:0]   key_pool [$];
	bit                 req_idle_on = 1'b1;
	bit                 rsp_idle_on = 1'b1;
	bit                 rsp_hold_request = 1'b0;
	int                 n_put = 0, n_get = 0, n_remove = 0;

	open_addressing_hash_map #(
		.SLOT_COUNT(SLOTS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Leaves valid high on return; drain_table, or the next call when it waits, lowers it.
	task automatic send_item(op_t op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
		int gap;
		gap = req_idle_on ? $urandom_range(0, 9) : 0;
		if ($urandom_range(0, 39) == 0)
			req_idle_on = !req_idle_on;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.key       <= k;
		req_ch.value     <= v;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		sb.note_request(op, k, v);
		case (op)
			OP_PUT:    n_put++;
			OP_GET:    n_get++;
			OP_REMOVE: n_remove++;
			default: ;
		endcase
	endtask

	// Hold the sender until every outstanding response has come back.
	task automatic drain_table();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pool_key();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// Mostly known keys, some forced into a small window of home slots that
	// wraps past the last slot, the rest fully random.
	task automatic random_op();
		int               r;
		op_t              op;
		logic [KEY_W-1:0] k;
		r  = $urandom_range(0, 99);
		op = (r < 45) ? OP_PUT : (r < 80) ? OP_GET : OP_REMOVE;
		r  = $urandom_range(0, 99);
		if (r < 60 && key_pool.size() > 0)
			k = pool_key();
		else if (r < 80)
			k = sb.key_with_home((CLUSTER_BASE + $urandom_range(0, 15)) % SLOTS);
		else
			k = $urandom;
		if (op == OP_PUT)
			key_pool.push_back(k);
		send_item(op, k, VALUE_W'($urandom));
	endtask

	initial begin : rsp_side
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold_request) begin
				rsp_hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			gap = rsp_idle_on ? $urandom_range(0, 9) : 0;
			if ($urandom_range(0, 39) == 0)
				rsp_idle_on = !rsp_idle_on;
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (rsp_ch.valid !== 1'b1);
			sb.check_response(rsp_ch.status, rsp_ch.value_out, rsp_ch.live_entries);
		end
	end

	initial begin
		#60_000_000;
		$display("timeout with %0d responses outstanding", sb.pending());
		$display("[open_addressing_hash_map] ERROR");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] k_a, k_b, k_c, k_d, k;
		int               r;
		sb = new();
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_PUT;
		req_ch.key       <= '0;
		req_ch.value     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// four keys sharing the last home slot, so their chain wraps to slot 0
		k_a = sb.key_with_home(SLOTS - 1);
		k_b = sb.key_with_home(SLOTS - 1);
		k_c = sb.key_with_home(SLOTS - 1);
		k_d = sb.key_with_home(SLOTS - 1);

		send_item(OP_GET,    32'h0000_0000, 10'd0);
		send_item(OP_REMOVE, 32'h0000_0000, 10'h3ff);
		send_item(OP_PUT,    32'h0000_0000, 10'd0);
		send_item(OP_PUT,    32'hffff_ffff, 10'h3ff);
		send_item(OP_PUT,    32'h8000_0000, 10'h200);
		send_item(OP_PUT,    32'h7fff_ffff, 10'h155);
		send_item(OP_GET,    32'hffff_ffff, 10'd0);
		send_item(OP_PUT,    32'hffff_ffff, 10'd5);
		send_item(OP_GET,    32'hffff_ffff, 10'h3ff);
		send_item(OP_PUT,    k_a, 10'h2aa);
		send_item(OP_PUT,    k_b, 10'h0f0);
		send_item(OP_PUT,    k_c, 10'h30f);
		send_item(OP_REMOVE, k_b, 10'd0);
		send_item(OP_GET,    k_c, 10'd0);
		send_item(OP_PUT,    k_d, 10'h111);
		send_item(OP_GET,    k_d, 10'd0);
		send_item(OP_REMOVE, k_a, 10'd0);
		send_item(OP_REMOVE, k_a, 10'd0);
		send_item(OP_PUT,    k_c, 10'h001);
		send_item(OP_GET,    k_c, 10'd0);
		send_item(OP_GET,    k_a, 10'd0);
		send_item(OP_REMOVE, 32'h8000_0000, 10'd0);
		send_item(OP_GET,    32'h8000_0000, 10'd0);
		send_item(OP_GET,    32'h7fff_ffff, 10'd0);
		send_item(OP_GET,    32'h0000_0000, 10'd0);
		key_pool = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			k_a, k_b, k_c, k_d};
		drain_table();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 150)
				rsp_hold_request = 1'b1;
			if (i == 300)
				drain_table();
			random_op();
		end

		// mixed traffic after a full drain, including misses on random keys
		drain_table();
		for (int i = 0; i < TAIL_ITEMS; i++) begin
			r = $urandom_range(0, 4);
			case (r)
				0: begin
					k = $urandom;
					key_pool.push_back(k);
					send_item(OP_PUT, k, VALUE_W'($urandom));
				end
				1: send_item(OP_PUT, pool_key(), VALUE_W'($urandom));
				2: send_item(OP_GET, pool_key(), VALUE_W'($urandom));
				3: send_item(OP_GET, $urandom, VALUE_W'($urandom));
				default: send_item(OP_REMOVE, pool_key(), VALUE_W'($urandom));
			endcase
		end

		drain_table();
		repeat (SLOTS + 16) @(posedge clk);
		$display("covered %0d requests: %0d put, %0d get, %0d remove, long response stall",
			n_put + n_get + n_remove, n_put, n_get, n_remove);
		$display("responses: %0d ok, %0d absent, %0d full; %0d mismatches",
			sb.n_ok, sb.n_absent, sb.n_full, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[open_addressing_hash_map] OK");
		end else begin
			$display("[open_addressing_hash_map] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
